// ===== hw/rtl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// Shared widths, operation and status codes, and the control bundle that
// the store broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned ST_W   = 2;

  localparam int unsigned DEFAULT_CAPACITY = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
  localparam logic [OP_W-1:0] OP_READ       = 3'd6;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Broadcast to each cell: open a gap at the position, or close one there
  typedef struct packed {
    logic              shift_in;
    logic              shift_out;
    logic [DATA_W-1:0] wdata;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/isp_cell.sv =====
// ----------------------------------------------------------------------------
// isp_cell
// One slot of the sequence. Compares its own index with the broadcast
// position, loads from its left or right neighbor or from the write word,
// and offers its word on the read and last-entry taps.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_cell #(
  parameter int unsigned CMP_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  wire logic                        clk_i,
  input  wire isp_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [CMP_W-1:0]            pos_i,
  input  wire logic [CMP_W-1:0]            count_i,
  input  wire logic [isp_pkg::DATA_W-1:0]  left_i,
  input  wire logic [isp_pkg::DATA_W-1:0]  right_i,
  output logic      [isp_pkg::DATA_W-1:0]  data_o,
  output logic      [isp_pkg::DATA_W-1:0]  rd_tap_o,
  output logic      [isp_pkg::DATA_W-1:0]  last_tap_o
);
  import isp_pkg::*;

  localparam logic [CMP_W-1:0] IDX      = CMP_W'(INDEX);
  localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(INDEX + 1);

  logic [DATA_W-1:0] data_q, data_d;

  // Next word: insert opens a gap at pos, remove closes the gap at pos
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_in) begin
      if (IDX == pos_i) begin
        data_d = ctrl_i.wdata;
      end else if (IDX > pos_i) begin
        data_d = left_i;
      end
    end else if (ctrl_i.shift_out) begin
      if (IDX >= pos_i) begin
        data_d = right_i;
      end
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign rd_tap_o   = (IDX == pos_i) ? data_q : '0;
  assign last_tap_o = (IDX_NEXT == count_i) ? data_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_sequence_store.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Bounded ordered sequence of signed words with push/pop at both ends,
// indexed insert, remove and read, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: one transaction per clock. A command is taken at any edge with start
// high (busy stays low, the cell row absorbs one operation per cycle), and
// its result appears on the result ports in the very next cycle with done_o
// high for exactly that one cycle. The transaction rate comes from the cell
// row: every cell compares its index with the position and loads from a
// neighbor in the same cycle. The result cannot be held off, so capture it
// when done_o is high. Failed operations (full, empty, bad position) leave
// the contents and the count unchanged.
`default_nettype none

module indexed_sequence_store #(
  parameter int unsigned CAPACITY = isp_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [isp_pkg::OP_W-1:0]   opcode_i,
  input  wire logic        [isp_pkg::POS_W-1:0]  position_i,
  input  wire logic signed [isp_pkg::DATA_W-1:0] value_in_i,
  output logic                                   done_o,
  output logic signed      [isp_pkg::DATA_W-1:0] read_value_o,
  output logic signed      [isp_pkg::DATA_W-1:0] first_value_o,
  output logic signed      [isp_pkg::DATA_W-1:0] last_value_o,
  output logic             [isp_pkg::CNT_W-1:0]  entry_count_o,
  output logic             [isp_pkg::ST_W-1:0]   status_o
);
  import isp_pkg::*;

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;

  logic                fire;
  logic [CMP_W-1:0]    count_q, count_d;
  logic [CMP_W-1:0]    pos_x;
  logic [CMP_W-1:0]    op_pos;
  logic                do_ins, do_rem, do_rd;
  logic [ST_W-1:0]     st;
  cell_ctrl_t          ctrl;
  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [DATA_W-1:0]   rd_tap    [CAPACITY];
  logic [DATA_W-1:0]   last_tap  [CAPACITY];
  logic [DATA_W-1:0]   rd_sel, last_sel;
  logic                done_q;
  logic [DATA_W-1:0]   rd_q, rd_d;
  logic [ST_W-1:0]     status_q;
  logic                is_full, is_empty;

  // Cell row absorbs a command every cycle
  assign busy  = 1'b0;
  assign fire  = start && !busy;
  assign pos_x = CMP_W'(position_i);

  assign is_full  = (count_q >= CMP_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Command decode: checks, and which gap to open or close
  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_rd  = 1'b0;
    op_pos = pos_x;
    st     = ST_DONE;
    case (opcode_i)
      OP_PUSH_FRONT: begin
        op_pos = '0;
        if (is_full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_PUSH_BACK: begin
        op_pos = count_q;
        if (is_full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_POP_FRONT: begin
        op_pos = '0;
        if (is_empty) st = ST_EMPTY;
        else begin
          do_rem = 1'b1;
          do_rd  = 1'b1;
        end
      end
      OP_POP_BACK: begin
        op_pos = count_q - CMP_W'(1);
        if (is_empty) st = ST_EMPTY;
        else begin
          do_rem = 1'b1;
          do_rd  = 1'b1;
        end
      end
      OP_INSERT: begin
        if (is_full) st = ST_FULL;
        else if (pos_x > count_q) st = ST_RANGE;
        else do_ins = 1'b1;
      end
      OP_REMOVE: begin
        if (is_empty) st = ST_EMPTY;
        else if (pos_x >= count_q) st = ST_RANGE;
        else begin
          do_rem = 1'b1;
          do_rd  = 1'b1;
        end
      end
      OP_READ: begin
        if (is_empty) st = ST_EMPTY;
        else if (pos_x >= count_q) st = ST_RANGE;
        else do_rd = 1'b1;
      end
      default: begin
        st = ST_DONE;
      end
    endcase
  end

  // Control bundle broadcast to the row
  always_comb begin
    ctrl.shift_in  = fire && do_ins;
    ctrl.shift_out = fire && do_rem;
    ctrl.wdata     = value_in_i;
  end

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_left_edge
      assign left_w = value_in_i;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_right_edge
      assign right_w = cell_data[i];
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    isp_cell #(
      .CMP_W (CMP_W),
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .pos_i      (op_pos),
      .count_i    (count_q),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[i]),
      .rd_tap_o   (rd_tap[i]),
      .last_tap_o (last_tap[i])
    );
  end

  // One-hot taps merged by OR
  always_comb begin
    rd_sel   = '0;
    last_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_sel   = rd_sel | rd_tap[k];
      last_sel = last_sel | last_tap[k];
    end
  end

  assign rd_d = do_rd ? rd_sel : '0;

  always_comb begin
    count_d = count_q;
    if (ctrl.shift_in) count_d = count_q + CMP_W'(1);
    else if (ctrl.shift_out) count_d = count_q - CMP_W'(1);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= fire;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_q     <= rd_d;
      status_q <= st;
    end
  end

  assign done_o        = done_q;
  assign read_value_o  = rd_q;
  assign status_o      = status_q;
  assign first_value_o = is_empty ? '0 : cell_data[0];
  assign last_value_o  = last_sel;
  assign entry_count_o = count_q[CNT_W-1:0];

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMP_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> done_o)
    else $error("result strobe missing after accepted command");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("entry count moved without a command");

  a_fail_no_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && st != ST_DONE) |=> (status_o != ST_DONE) && $stable(count_q))
    else $error("failed command changed the entry count");

  a_fail_zero_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> (read_value_o == '0))
    else $error("failed command returned a nonzero word");

endmodule

`default_nettype wire
